// ----- hdl/text_cell_line_renderer_defines.svh -----
// assertion macros for the text cell line renderer
`ifndef TEXT_CELL_LINE_RENDERER_DEFINES_SVH
`define TEXT_CELL_LINE_RENDERER_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define TCLR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tclr check failed");
// antecedent implies consequent in the next cycle
`define TCLR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tclr check failed");
`else
`define TCLR_ASSERT_NOW(label, ante, cons)
`define TCLR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- hdl/tclr_pkg.sv -----
// types, constants and tables shared by the text cell line renderer
package tclr_pkg;

    localparam int CODE_COUNT  = 256;
    localparam int CODE_W      = $clog2(CODE_COUNT);
    localparam int ROW_W       = 3;
    localparam int STORE_DEPTH = CODE_COUNT * 8;
    localparam int ADDR_W      = CODE_W + ROW_W;

    localparam int BYTE_W      = 8;
    localparam int COLOR_W     = 3;
    localparam int BLINK_W     = 5;
    localparam int IN_DATA_W   = 32;
    localparam int FUNC_W      = 2;
    localparam int PIXEL_W     = 48;
    localparam int PIX_COUNT   = 8;

    // attribute bit positions
    localparam int ATTR_INVERT = 3;
    localparam int ATTR_BLINK  = 4;
    localparam int ATTR_PROG   = 5;
    localparam int ATTR_WIDE   = 7;
    localparam int BLINK_PHASE = 3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_RENDER = 2'd0,
        FUNC_GLYPH  = 2'd1,
        FUNC_PLANE  = 2'd2,
        FUNC_TICK   = 2'd3
    } func_t;

    localparam logic [1:0] PLANE_BLUE  = 2'd0;
    localparam logic [1:0] PLANE_RED   = 2'd1;
    localparam logic [1:0] PLANE_GREEN = 2'd2;

    // control carried alongside the store read
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               invert;
        logic               wide;
        logic               prog;
    } render_ctl_t;

    typedef logic [CODE_W-1:0] wrap_table_t [256];

    // code wrap modulo the number of codes, built at elaboration
    function automatic wrap_table_t build_wrap_table();
        wrap_table_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = CODE_W'(i % CODE_COUNT);
        end
        return t;
    endfunction

    localparam wrap_table_t WRAP_TABLE = build_wrap_table();

endpackage

// ----- hdl/tclr_ram.sv -----
// generic single-port-write ram with registered read
module tclr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/text_cell_line_renderer.sv -----
// text cell line renderer top level: glyph and plane stores, blink and pixel expansion
// Text-plane character generator. One item is taken per clock while the result side does not
// stall; a render item's pixel line passes through the registered read of the glyph and plane
// rams and then the output register. Write and frame tick items give no result. The rams are
// not cleared after reset: a cell line must be written before it is rendered. Blink state is
// sampled when the render item is taken, so a later frame tick does not affect it.
`include "text_cell_line_renderer_defines.svh"

module text_cell_line_renderer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // char_code[7:0], attribute[15:8], cell_row[18:16], plane[20:19],
    // write_byte[28:21], zero pad[31:29]
    input  logic [tclr_pkg::IN_DATA_W-1:0]  s_tdata,
    // func[1:0]
    input  logic [tclr_pkg::FUNC_W-1:0]     s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pixel_row[47:0]
    output logic [tclr_pkg::PIXEL_W-1:0]    m_tdata,
    // is_wide[0]
    output logic                            m_tuser
);
    import tclr_pkg::*;

    logic [BYTE_W-1:0]  in_code;
    logic [BYTE_W-1:0]  in_attr;
    logic [ROW_W-1:0]   in_row;
    logic [1:0]         in_plane;
    logic [BYTE_W-1:0]  in_wbyte;
    func_t              in_func;
    logic [ADDR_W-1:0]  store_addr;

    logic               s_fire;
    logic               load_render;
    logic               adv_out;

    logic [BLINK_W-1:0] blink_reg, blink_next;
    logic               s1_valid_reg, s1_valid_next;
    render_ctl_t        s1_ctl_reg, s1_ctl_next;

    logic [BYTE_W-1:0]  glyph_rd, blue_rd, red_rd, green_rd;

    logic               m_valid_reg, m_valid_next;
    logic [PIXEL_W-1:0] pixel_reg, pixel_next;
    logic               wide_reg, wide_next;

    logic [BYTE_W-1:0]  pat_b, pat_r, pat_g, pat_glyph;
    logic [COLOR_W-1:0] pix [PIX_COUNT];

    assign in_code  = s_tdata[7:0];
    assign in_attr  = s_tdata[15:8];
    assign in_row   = s_tdata[18:16];
    assign in_plane = s_tdata[20:19];
    assign in_wbyte = s_tdata[28:21];
    assign in_func  = func_t'(s_tuser);

    assign store_addr = {WRAP_TABLE[in_code], in_row};

    assign adv_out     = !m_valid_reg || m_tready;
    assign s_tready    = !s1_valid_reg || adv_out;
    assign s_fire      = s_tvalid && s_tready;
    assign load_render = s_fire && (in_func == FUNC_RENDER);

    tclr_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_DEPTH)) u_glyph_ram (
        .aclk    (aclk),
        .wr_en   (s_fire && (in_func == FUNC_GLYPH)),
        .wr_addr (store_addr),
        .wr_data (in_wbyte),
        .rd_en   (load_render),
        .rd_addr (store_addr),
        .rd_data (glyph_rd)
    );

    tclr_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_DEPTH)) u_blue_ram (
        .aclk    (aclk),
        .wr_en   (s_fire && (in_func == FUNC_PLANE) && (in_plane == PLANE_BLUE)),
        .wr_addr (store_addr),
        .wr_data (in_wbyte),
        .rd_en   (load_render),
        .rd_addr (store_addr),
        .rd_data (blue_rd)
    );

    tclr_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_DEPTH)) u_red_ram (
        .aclk    (aclk),
        .wr_en   (s_fire && (in_func == FUNC_PLANE) && (in_plane == PLANE_RED)),
        .wr_addr (store_addr),
        .wr_data (in_wbyte),
        .rd_en   (load_render),
        .rd_addr (store_addr),
        .rd_data (red_rd)
    );

    tclr_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_DEPTH)) u_green_ram (
        .aclk    (aclk),
        .wr_en   (s_fire && (in_func == FUNC_PLANE) && (in_plane == PLANE_GREEN)),
        .wr_addr (store_addr),
        .wr_data (in_wbyte),
        .rd_en   (load_render),
        .rd_addr (store_addr),
        .rd_data (green_rd)
    );

    // input side: blink counter and render control next to the ram read
    always_comb begin
        blink_next    = blink_reg;
        s1_valid_next = s1_valid_reg;
        s1_ctl_next   = s1_ctl_reg;
        if (s_fire && (in_func == FUNC_TICK)) begin
            blink_next = blink_reg + BLINK_W'(1);
        end
        if (s_tready) begin
            s1_valid_next = load_render;
        end
        if (load_render) begin
            s1_ctl_next.color  = (in_attr[ATTR_BLINK] && blink_reg[BLINK_PHASE])
                                 ? COLOR_W'(0) : in_attr[COLOR_W-1:0];
            s1_ctl_next.invert = in_attr[ATTR_INVERT];
            s1_ctl_next.wide   = in_attr[ATTR_WIDE];
            s1_ctl_next.prog   = in_attr[ATTR_PROG];
        end
    end

    // pixel expansion
    always_comb begin
        pat_b     = s1_ctl_reg.color[0] ? blue_rd  : '0;
        pat_r     = s1_ctl_reg.color[1] ? red_rd   : '0;
        pat_g     = s1_ctl_reg.color[2] ? green_rd : '0;
        pat_glyph = glyph_rd;
        if (s1_ctl_reg.invert) begin
            pat_b     = ~pat_b;
            pat_r     = ~pat_r;
            pat_g     = ~pat_g;
            pat_glyph = ~pat_glyph;
        end
        for (int k = 0; k < PIX_COUNT; k++) begin
            // leftmost pixel comes from the msb
            if (s1_ctl_reg.prog) begin
                pix[k] = {pat_g[PIX_COUNT-1-k], pat_r[PIX_COUNT-1-k], pat_b[PIX_COUNT-1-k]};
            end else begin
                pix[k] = pat_glyph[PIX_COUNT-1-k] ? s1_ctl_reg.color : COLOR_W'(0);
            end
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        pixel_next   = pixel_reg;
        wide_next    = wide_reg;
        if (adv_out) begin
            m_valid_next = s1_valid_reg;
        end
        if (adv_out && s1_valid_reg) begin
            pixel_next = '0;
            wide_next  = s1_ctl_reg.wide;
            for (int k = 0; k < PIX_COUNT; k++) begin
                if (s1_ctl_reg.wide) begin
                    pixel_next[2*COLOR_W*k +: COLOR_W]           = pix[k];
                    pixel_next[2*COLOR_W*k + COLOR_W +: COLOR_W] = pix[k];
                end else begin
                    pixel_next[COLOR_W*k +: COLOR_W] = pix[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_reg    <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            blink_reg    <= blink_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
        s1_ctl_reg <= s1_ctl_next;
        pixel_reg  <= pixel_next;
        wide_reg   <= wide_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = pixel_reg;
    assign m_tuser  = wide_reg;

    `TCLR_ASSERT_NEXT(a_render_enters, load_render, s1_valid_reg)
    `TCLR_ASSERT_NEXT(a_nonrender_no_result, s_fire && (in_func != FUNC_RENDER), !s1_valid_reg)
    `TCLR_ASSERT_NEXT(a_tick_counts, s_fire && (in_func == FUNC_TICK),
                      blink_reg == $past(blink_reg) + BLINK_W'(1))
    `TCLR_ASSERT_NOW(a_narrow_upper_zero, m_valid_reg && !wide_reg,
                     pixel_reg[PIXEL_W-1:PIXEL_W/2] == '0)

endmodule

// ----- dv/tb_text_cell_line_renderer.sv -----
// testbench for the text cell line renderer: directed table then random cell traffic
module tb_text_cell_line_renderer;
    import tclr_pkg::*;

    localparam int ITEM_TARGET     = 750;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 10;
    localparam int REPORT_LIMIT    = 10;
    localparam int DIRECTED_COUNT  = 25;
    localparam logic [1:0] PLANE_NONE = 2'd3;

    typedef struct packed {
        func_t             fn;
        logic [BYTE_W-1:0] code;
        logic [BYTE_W-1:0] attr;
        logic [ROW_W-1:0]  row;
        logic [1:0]        plane;
        logic [BYTE_W-1:0] wbyte;
    } cell_item_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixels;
        logic               wide;
    } cell_line_t;

    typedef struct packed {
        cell_item_t item;
        logic       typed;
        cell_line_t line;
    } directed_row_t;

    localparam cell_line_t NO_LINE = '0;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata  = '0;
    logic [FUNC_W-1:0]    s_tuser  = FUNC_RENDER;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [PIXEL_W-1:0]   m_tdata;
    logic                 m_tuser;

    // mirror of the glyph and plane stores plus the blink counter
    logic [BYTE_W-1:0]  glyph_mem [STORE_DEPTH];
    logic [BYTE_W-1:0]  plane_mem [3][STORE_DEPTH];
    bit                 glyph_set [STORE_DEPTH];
    bit [2:0]           plane_set [STORE_DEPTH];
    logic [BLINK_W-1:0] blink_count = '0;

    // cell lines that are safe to render
    logic [ADDR_W-1:0] glyph_lines [$];
    logic [ADDR_W-1:0] plane_lines [$];

    cell_line_t expected_lines [$];
    int         fail_count  = 0;
    int         items_sent  = 0;
    int         burst_left  = 0;
    int         cycle_count = 0;

    directed_row_t directed_rows [DIRECTED_COUNT] = '{
        '{'{FUNC_GLYPH,  8'h00, 8'h00, 3'd0, PLANE_BLUE,  8'hff}, 1'b0, NO_LINE},
        '{'{FUNC_GLYPH,  8'hff, 8'hff, 3'd7, PLANE_NONE,  8'h80}, 1'b0, NO_LINE},
        '{'{FUNC_GLYPH,  8'h55, 8'h40, 3'd3, PLANE_RED,   8'h00}, 1'b0, NO_LINE},
        '{'{FUNC_RENDER, 8'h00, 8'h07, 3'd0, PLANE_BLUE,  8'h00}, 1'b1,
            '{48'h0000_00ff_ffff, 1'b0}},
        '{'{FUNC_RENDER, 8'h00, 8'h87, 3'd0, PLANE_BLUE,  8'h00}, 1'b1,
            '{48'hffff_ffff_ffff, 1'b1}},
        '{'{FUNC_RENDER, 8'hff, 8'h01, 3'd7, PLANE_NONE,  8'hff}, 1'b1,
            '{48'h0000_0000_0001, 1'b0}},
        // inverted empty glyph fills the line
        '{'{FUNC_RENDER, 8'h55, 8'h0f, 3'd3, PLANE_GREEN, 8'h00}, 1'b1,
            '{48'h0000_00ff_ffff, 1'b0}},
        '{'{FUNC_PLANE,  8'h10, 8'h00, 3'd1, PLANE_BLUE,  8'hf0}, 1'b0, NO_LINE},
        '{'{FUNC_PLANE,  8'h10, 8'h00, 3'd1, PLANE_RED,   8'h0f}, 1'b0, NO_LINE},
        '{'{FUNC_PLANE,  8'h10, 8'h00, 3'd1, PLANE_GREEN, 8'hff}, 1'b0, NO_LINE},
        // selector three must leave every plane alone
        '{'{FUNC_PLANE,  8'h10, 8'h00, 3'd1, PLANE_NONE,  8'h00}, 1'b0, NO_LINE},
        '{'{FUNC_RENDER, 8'h10, 8'h27, 3'd1, PLANE_BLUE,  8'h00}, 1'b0, NO_LINE},
        '{'{FUNC_RENDER, 8'h10, 8'h2d, 3'd1, PLANE_BLUE,  8'h00}, 1'b0, NO_LINE},
        // colour 0 masks all planes, inversion then sets them
        '{'{FUNC_RENDER, 8'h10, 8'ha8, 3'd1, PLANE_BLUE,  8'h00}, 1'b1,
            '{48'hffff_ffff_ffff, 1'b1}},
        '{'{FUNC_RENDER, 8'h00, 8'h17, 3'd0, PLANE_BLUE,  8'h00}, 1'b0, NO_LINE},
        '{'{FUNC_TICK,   8'hff, 8'hff, 3'd7, PLANE_NONE,  8'hff}, 1'b0, NO_LINE},
        '{'{FUNC_TICK,   8'h00, 8'h00, 3'd0, PLANE_BLUE,  8'h00}, 1'b0, NO_LINE},
        '{'{FUNC_TICK,   8'ha5, 8'h5a, 3'd5, PLANE_RED,   8'h3c}, 1'b0, NO_LINE},
        '{'{FUNC_TICK,   8'h00, 8'h00, 3'd0, PLANE_BLUE,  8'h00}, 1'b0, NO_LINE},
        '{'{FUNC_TICK,   8'h00, 8'h00, 3'd0, PLANE_BLUE,  8'h00}, 1'b0, NO_LINE},
        '{'{FUNC_TICK,   8'h00, 8'h00, 3'd0, PLANE_BLUE,  8'h00}, 1'b0, NO_LINE},
        '{'{FUNC_TICK,   8'h00, 8'h00, 3'd0, PLANE_BLUE,  8'h00}, 1'b0, NO_LINE},
        '{'{FUNC_TICK,   8'h00, 8'h00, 3'd0, PLANE_BLUE,  8'h00}, 1'b0, NO_LINE},
        // blink phase now set: blinking cells vanish
        '{'{FUNC_RENDER, 8'h00, 8'h17, 3'd0, PLANE_BLUE,  8'h00}, 1'b1,
            '{48'h0000_0000_0000, 1'b0}},
        '{'{FUNC_RENDER, 8'h10, 8'hf7, 3'd1, PLANE_NONE,  8'hff}, 1'b1,
            '{48'h0000_0000_0000, 1'b1}}
    };

    text_cell_line_renderer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void note_failure(string msg);
        if (fail_count < REPORT_LIMIT) begin
            $display("mismatch: %s", msg);
        end
        fail_count++;
    endfunction

    function automatic cell_line_t render_line(logic [BYTE_W-1:0] attr, logic [ADDR_W-1:0] idx);
        cell_line_t         line;
        logic [COLOR_W-1:0] color;
        logic [COLOR_W-1:0] px;
        logic [BYTE_W-1:0]  blue;
        logic [BYTE_W-1:0]  red;
        logic [BYTE_W-1:0]  green;
        logic [BYTE_W-1:0]  pat;
        color = (attr[ATTR_BLINK] && blink_count[BLINK_PHASE]) ? '0 : attr[COLOR_W-1:0];
        blue  = color[0] ? plane_mem[PLANE_BLUE][idx]  : '0;
        red   = color[1] ? plane_mem[PLANE_RED][idx]   : '0;
        green = color[2] ? plane_mem[PLANE_GREEN][idx] : '0;
        pat   = glyph_mem[idx];
        // inversion comes after the colour mask
        if (attr[ATTR_INVERT]) begin
            blue  = ~blue;
            red   = ~red;
            green = ~green;
            pat   = ~pat;
        end
        line.pixels = '0;
        line.wide   = attr[ATTR_WIDE];
        for (int k = 0; k < PIX_COUNT; k++) begin
            if (attr[ATTR_PROG]) begin
                px = {green[7-k], red[7-k], blue[7-k]};
            end else begin
                px = pat[7-k] ? color : '0;
            end
            if (line.wide) begin
                line.pixels[6*k +: 3]   = px;
                line.pixels[6*k+3 +: 3] = px;
            end else begin
                line.pixels[3*k +: 3] = px;
            end
        end
        return line;
    endfunction

    task automatic model_item(input cell_item_t it, output bit has_line, output cell_line_t line);
        logic [ADDR_W-1:0] idx;
        idx      = {CODE_W'(it.code % CODE_COUNT), it.row};
        has_line = 1'b0;
        line     = NO_LINE;
        case (it.fn)
            FUNC_GLYPH: begin
                glyph_mem[idx] = it.wbyte;
                if (!glyph_set[idx]) glyph_lines.push_back(idx);
                glyph_set[idx] = 1'b1;
            end
            FUNC_PLANE: begin
                if (it.plane != PLANE_NONE) begin
                    plane_mem[it.plane][idx] = it.wbyte;
                    if (plane_set[idx] != 3'b111) begin
                        plane_set[idx][it.plane] = 1'b1;
                        if (plane_set[idx] == 3'b111) plane_lines.push_back(idx);
                    end
                end
            end
            FUNC_TICK: begin
                blink_count = blink_count + 1'b1;
            end
            default: begin
                has_line = 1'b1;
                line     = render_line(it.attr, idx);
            end
        endcase
    endtask

    task automatic idle_gap();
        int gap;
        int pick;
        gap = 0;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 2) burst_left = $urandom_range(20, 60);
            if (pick >= 97) begin
                gap = $urandom_range(15, 40);
            end else if (pick >= 90) begin
                gap = $urandom_range(4, 10);
            end else if (pick >= 55) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_item(cell_item_t it, logic typed, cell_line_t typed_line);
        bit         has_line;
        cell_line_t line;
        s_tvalid <= 1'b1;
        s_tuser  <= it.fn;
        s_tdata  <= {3'b000, it.wbyte, it.plane, it.row, it.attr, it.code};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // blink state is taken at the transfer, so the model steps here
        model_item(it, has_line, line);
        if (has_line) expected_lines.push_back(typed ? typed_line : line);
        items_sent++;
        idle_gap();
    endtask

    function automatic cell_item_t make_item(func_t fn, logic [ADDR_W-1:0] idx);
        cell_item_t it;
        it.fn    = fn;
        it.code  = BYTE_W'(idx >> ROW_W);
        it.row   = idx[ROW_W-1:0];
        it.attr  = BYTE_W'($urandom_range(0, 255));
        it.plane = 2'($urandom_range(0, 3));
        it.wbyte = BYTE_W'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic render_at(logic [ADDR_W-1:0] idx, logic [BYTE_W-1:0] attr);
        cell_item_t it;
        it      = make_item(FUNC_RENDER, idx);
        it.attr = attr;
        send_item(it, 1'b0, NO_LINE);
    endtask

    // render a line already written, glyph or planes as the attribute asks
    task automatic render_known(logic [BYTE_W-1:0] attr);
        logic [ADDR_W-1:0] idx;
        if (attr[ATTR_PROG] && plane_lines.size() == 0) attr[ATTR_PROG] = 1'b0;
        if (!attr[ATTR_PROG] && glyph_lines.size() == 0) attr[ATTR_PROG] = 1'b1;
        if (attr[ATTR_PROG]) begin
            idx = plane_lines[$urandom_range(0, plane_lines.size() - 1)];
        end else begin
            idx = glyph_lines[$urandom_range(0, glyph_lines.size() - 1)];
        end
        render_at(idx, attr);
    endtask

    function automatic logic [ADDR_W-1:0] random_line();
        return ADDR_W'($urandom_range(0, STORE_DEPTH - 1));
    endfunction

    initial begin
        int                pick;
        int                reps;
        logic [ADDR_W-1:0] idx;
        logic [BYTE_W-1:0] attr;
        cell_item_t        it;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].line);
        end

        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                send_item(make_item(FUNC_TICK, random_line()), 1'b0, NO_LINE);
            end else if (pick < 22) begin
                // define a glyph line, then show it
                idx = random_line();
                send_item(make_item(FUNC_GLYPH, idx), 1'b0, NO_LINE);
                reps = $urandom_range(1, 3);
                repeat (reps) begin
                    attr = BYTE_W'($urandom_range(0, 255));
                    attr[ATTR_PROG] = 1'b0;
                    render_at(idx, attr);
                end
            end else if (pick < 34) begin
                // define a programmable line on all three planes, then show it
                idx = random_line();
                for (int p = 0; p < 3; p++) begin
                    it       = make_item(FUNC_PLANE, idx);
                    it.plane = 2'(p);
                    send_item(it, 1'b0, NO_LINE);
                end
                reps = $urandom_range(1, 3);
                repeat (reps) begin
                    attr = BYTE_W'($urandom_range(0, 255));
                    attr[ATTR_PROG] = 1'b1;
                    render_at(idx, attr);
                end
            end else if (pick < 42) begin
                send_item(make_item(FUNC_PLANE, random_line()), 1'b0, NO_LINE);
            end else if (pick < 48) begin
                // overwrite a line that is already in use
                idx = glyph_lines[$urandom_range(0, glyph_lines.size() - 1)];
                send_item(make_item(FUNC_GLYPH, idx), 1'b0, NO_LINE);
            end else begin
                render_known(BYTE_W'($urandom_range(0, 255)));
            end
        end
        s_tvalid <= 1'b0;

        while (expected_lines.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // result side back-pressure: short stalls, some long ones, some long open runs
    initial begin
        int run;
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
            repeat (run) @(posedge aclk);
            m_tready <= 1'b0;
            stall = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
            repeat (stall) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        cell_line_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_lines.size() == 0) begin
                note_failure($sformatf("unexpected line pixels %h wide %b", m_tdata, m_tuser));
            end else begin
                want = expected_lines.pop_front();
                if (m_tdata !== want.pixels) begin
                    note_failure($sformatf("pixels expected %h actual %h",
                                           want.pixels, m_tdata));
                end
                if (m_tuser !== want.wide) begin
                    note_failure($sformatf("is_wide expected %b actual %b", want.wide, m_tuser));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/tclr_pkg.sv
hdl/tclr_ram.sv
hdl/text_cell_line_renderer.sv
dv/tb_text_cell_line_renderer.sv
